// File: hw/rtl/acph_pkg.sv
package acph_pkg;

  localparam int CHAR_W    = 8;
  localparam int HASH_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int VAL_W     = 6;
  localparam int PROD_W    = 2 * HASH_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PC_W      = 2;

  // Character set bounds and the gap left in the value range
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_LO = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_HI = 8'd90;
  localparam logic [VAL_W-1:0]  ALPHA_OFFSET  = 6'd11;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 1'd1;
  localparam logic [CFG_W-1:0]     MODULUS_RST = 16'd101;
  localparam logic [CFG_W-1:0]     BASE_RST    = 16'd37;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } in_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic              bad_char;
  } out_t;

  // Sequencer jump conditions
  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_NO_XFER  = 2'd1,
    COND_NOT_DONE = 2'd2,
    COND_OUT_BUSY = 2'd3
  } cond_t;

  typedef struct packed {
    logic            in_rdy;
    logic            mul_load;
    logic            div_step;
    logic            wb;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] STEP_TAKE = 2'd0;
  localparam logic [PC_W-1:0] STEP_MUL  = 2'd1;
  localparam logic [PC_W-1:0] STEP_DIV  = 2'd2;
  localparam logic [PC_W-1:0] STEP_WB   = 2'd3;

  // Control store; a step that does not jump falls through to the next,
  // and the writeback step wraps round to the take step.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      STEP_TAKE: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_NO_XFER;
        w.target = STEP_TAKE;
      end
      STEP_MUL: begin
        w.mul_load = 1'b1;
        w.cond     = COND_NEVER;
        w.target   = STEP_MUL;
      end
      STEP_DIV: begin
        w.div_step = 1'b1;
        w.cond     = COND_NOT_DONE;
        w.target   = STEP_DIV;
      end
      STEP_WB: begin
        w.wb     = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_WB;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/alnum_code_poly_hash_top.sv
// Polynomial hash of an alphanumeric code string, one character per input
// transfer with last_char on the final one. Each character passes through
// a take step, a step that forms the two products, the steps of a pair of
// bit-serial restoring remainder units (one per 32-bit product, run side by
// side) and a writeback step. The result of a string is loaded into the output
// register at the writeback of its last character, while the block goes on
// to take the next character; that writeback waits only if the previous
// result has not yet been taken. A modulus of 0 acts as 1.
module alnum_code_poly_hash_top import acph_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  uword_t            uw;

  logic [CFG_W-1:0]  modulus;
  logic [CFG_W-1:0]  base;
  logic [HASH_W-1:0] m;

  logic [HASH_W-1:0] sum;
  logic [HASH_W-1:0] bp;
  logic              err;

  logic [VAL_W-1:0]  val_q;
  logic              legal_q;
  logic              last_q;

  logic [PROD_W-1:0] div_a;
  logic [PROD_W-1:0] div_b;
  logic [HASH_W-1:0] rem_a;
  logic [HASH_W-1:0] rem_b;
  logic [CNT_W-1:0]  cnt;

  logic              in_xfer;
  logic              out_busy;
  logic              wb_fire;
  logic              jump;
  logic              err_next;
  logic [VAL_W-1:0]  val_in;
  logic              legal_in;
  logic [HASH_W:0]   t_a;
  logic [HASH_W:0]   t_b;
  logic [HASH_W-1:0] rem_a_next;
  logic [HASH_W-1:0] rem_b_next;

  assign uw       = ucode(pc);
  assign in_ready = uw.in_rdy;
  assign in_xfer  = in_valid && in_ready;
  assign m        = (modulus == '0) ? HASH_W'(1) : modulus;
  assign out_busy = last_q && out_valid && !out_ready;
  assign wb_fire  = uw.wb && !out_busy;
  assign err_next = err || !legal_q;

  always_comb begin
    val_in   = '0;
    legal_in = 1'b0;
    if (in_item.char_code >= CHAR_DIGIT_LO && in_item.char_code <= CHAR_DIGIT_HI) begin
      val_in   = VAL_W'(in_item.char_code - CHAR_DIGIT_LO);
      legal_in = 1'b1;
    end else if (in_item.char_code >= CHAR_ALPHA_LO &&
                 in_item.char_code <= CHAR_ALPHA_HI) begin
      val_in   = VAL_W'(in_item.char_code - CHAR_ALPHA_LO) + ALPHA_OFFSET;
      legal_in = 1'b1;
    end
  end

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_XFER:  jump = !in_valid;
      COND_NOT_DONE: jump = (cnt != CNT_W'(DIV_STEPS - 1));
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : pc + PC_W'(1);
  end

  // One restoring step per lane: remainder stays below m, so one subtract
  always_comb begin
    t_a = {rem_a, div_a[PROD_W-1]};
    t_b = {rem_b, div_b[PROD_W-1]};
    rem_a_next = (t_a >= {1'b0, m}) ? HASH_W'(t_a - {1'b0, m}) : t_a[HASH_W-1:0];
    rem_b_next = (t_b >= {1'b0, m}) ? HASH_W'(t_b - {1'b0, m}) : t_b[HASH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_TAKE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RST;
      base    <= BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS: modulus <= cfg_data;
        REG_BASE:    base    <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Take: decode the character; an illegal one adds nothing
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      val_q   <= legal_in ? val_in : '0;
      legal_q <= legal_in;
      last_q  <= in_item.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.mul_load) begin
      div_a <= PROD_W'(sum) + PROD_W'(PROD_W'(val_q) * PROD_W'(bp));
      div_b <= PROD_W'(bp) * PROD_W'(base);
      rem_a <= '0;
      rem_b <= '0;
      cnt   <= '0;
    end else if (uw.div_step) begin
      div_a <= div_a << 1;
      div_b <= div_b << 1;
      rem_a <= rem_a_next;
      rem_b <= rem_b_next;
      cnt   <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      bp  <= HASH_W'(1);
      err <= 1'b0;
    end else if (wb_fire) begin
      if (last_q) begin
        sum <= '0;
        bp  <= (m == HASH_W'(1)) ? '0 : HASH_W'(1);
        err <= 1'b0;
      end else begin
        sum <= rem_a;
        bp  <= rem_b;
        err <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_fire && last_q) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire && last_q) begin
      out_item.hash_value <= err_next ? '0 : rem_a;
      out_item.bad_char   <= err_next;
    end
  end

endmodule

// File: hw/rtl/acph_checker.sv
module acph_checker import acph_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_item
);

  // A waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped or changed while stalled");

  // An error result always carries a zero hash
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bad_char |-> out_item.hash_value == '0)
    else $error("bad_char result with non-zero hash");

  // One character at a time: no take in the cycle after a take
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // Reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state not cleared by reset");

endmodule

bind alnum_code_poly_hash_top acph_checker u_acph_checker (.*);

// File: test/alnum_code_poly_hash_top_test.sv
`timescale 1ns / 100ps

module alnum_code_poly_hash_top_test;
  import acph_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 40;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Predictor state and register copies
  logic [CFG_W-1:0]  cur_modulus;
  logic [CFG_W-1:0]  cur_base;
  logic [HASH_W-1:0] hash_sum;
  logic [HASH_W-1:0] hash_pow;
  logic              hash_err;
  out_t              expected_hashes[$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int idle_cycles;

  alnum_code_poly_hash_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Fold one character into the running hash; queue a result on the last one
  task automatic fold_char(input in_t item);
    logic [31:0] m;
    logic [31:0] v;
    logic [31:0] term;
    logic        legal;
    out_t        res;
    m = (cur_modulus == '0) ? 32'd1 : {16'd0, cur_modulus};
    legal = 1'b1;
    v = '0;
    if (item.char_code >= CHAR_DIGIT_LO && item.char_code <= CHAR_DIGIT_HI) begin
      v = item.char_code - CHAR_DIGIT_LO;
    end else if (item.char_code >= CHAR_ALPHA_LO && item.char_code <= CHAR_ALPHA_HI) begin
      v = item.char_code - CHAR_ALPHA_LO + ALPHA_OFFSET;
    end else begin
      legal = 1'b0;
    end
    if (legal) begin
      term = (v * (hash_pow % m)) % m;
      hash_sum = 16'(((hash_sum % m) + term) % m);
    end else begin
      hash_err = 1'b1;
    end
    // the power advances even past an illegal character
    hash_pow = 16'(((hash_pow % m) * (cur_base % m)) % m);
    if (item.last_char) begin
      res.hash_value = hash_err ? '0 : 16'(hash_sum % m);
      res.bad_char   = hash_err;
      expected_hashes.push_back(res);
      hash_sum = '0;
      hash_pow = 16'(32'd1 % m);
      hash_err = 1'b0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic last);
    in_t item;
    item.char_code = code;
    item.last_char = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    fold_char(item);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  function automatic logic [CHAR_W-1:0] pick_char(input int bad_pct);
    logic [CHAR_W-1:0] c;
    int                k;
    if ($urandom_range(99) < bad_pct) begin
      do begin
        c = CHAR_W'($urandom_range(255));
      end while ((c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) ||
                 (c >= CHAR_ALPHA_LO && c <= CHAR_ALPHA_HI));
    end else begin
      k = $urandom_range(35);
      c = (k < 10) ? CHAR_W'(CHAR_DIGIT_LO + k) : CHAR_W'(CHAR_ALPHA_LO + k - 10);
    end
    return c;
  endfunction

  // Drop valid, drain every expected result, then let the last character finish
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODULUS) begin
      cur_modulus = val;
    end else begin
      cur_base = val;
    end
  endtask

  task automatic test_directed();
    send_text("0");
    send_text("9");
    send_text("A");
    send_text("Z");
    send_text("Z9A0");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    // illegal at the end, at the start and throughout: the mark must stick
    send_text("A@");
    send_text("[5");
    send_text(":/");
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_MODULUS, '0);
    send_text("Z9");
    settle();
    write_reg(REG_MODULUS, 16'd1);
    write_reg(REG_BASE, 16'hFFFF);
    send_text("Z");
    settle();
    // power left at zero by the unit modulus carries into the next string
    write_reg(REG_MODULUS, 16'hFFFF);
    send_text("ZZZ");
    settle();
    write_reg(REG_BASE, '0);
    send_text("ZZ");
    settle();
  endtask

  task automatic test_random_strings(input int n_items, input int send_pct,
                                     input int recv_pct,
                                     input logic [CFG_W-1:0] modulus,
                                     input logic [CFG_W-1:0] base);
    int sent;
    int len;
    write_reg(REG_MODULUS, modulus);
    write_reg(REG_BASE, base);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        send_char(pick_char(3), i == len - 1);
      end
      sent += len;
    end
    settle();
  endtask

  always @(posedge clk) begin
    out_t exp_item;
    if (!rst && out_valid && out_ready) begin
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected result: hash %h bad_char %b",
                 $time, out_item.hash_value, out_item.bad_char);
        fail_count++;
      end else begin
        exp_item = expected_hashes.pop_front();
        if (out_item.hash_value !== exp_item.hash_value) begin
          $display("%0t: hash_value mismatch: expected %h actual %h",
                   $time, exp_item.hash_value, out_item.hash_value);
          fail_count++;
        end
        if (out_item.bad_char !== exp_item.bad_char) begin
          $display("%0t: bad_char mismatch: expected %b actual %b",
                   $time, exp_item.bad_char, out_item.bad_char);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_modulus   = MODULUS_RST;
    cur_base      = BASE_RST;
    hash_sum      = '0;
    hash_pow      = 16'd1;
    hash_err      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_register_extremes();
    test_random_strings(140, 24, 84, CFG_W'($urandom_range(65535, 2)),
                        CFG_W'($urandom_range(65535)));
    test_random_strings(140, 84, 24, CFG_W'($urandom_range(400)),
                        CFG_W'($urandom_range(65535)));
    test_random_strings(140, 0, 0, 16'd65521, CFG_W'($urandom_range(65535)));

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
